@@ design/tflc_pkg.sv @@
`timescale 1ns / 1ps

package tflc_pkg;

   // Opcodes of an input item
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_BATTERY_BASELINE = 3'd0;
   localparam logic [2:0] CSR_DEAD_ZONE        = 3'd1;
   localparam logic [2:0] CSR_BIG_STEP_ZONE    = 3'd2;
   localparam logic [2:0] CSR_COOLDOWN_TICKS   = 3'd3;
   localparam logic [2:0] CSR_CPU_LEVEL1       = 3'd4;
   localparam logic [2:0] CSR_CPU_LEVEL2       = 3'd5;
   localparam logic [2:0] CSR_CPU_LEVEL3       = 3'd6;
   localparam logic [2:0] CSR_CPU_CLEAR        = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   // Level and emergency codes
   localparam logic [3:0] LEVEL_TOP   = 4'd10;
   localparam logic [1:0] EMERG_NONE  = 2'd0;
   localparam logic [1:0] EMERG_LOW   = 2'd1;
   localparam logic [1:0] EMERG_MID   = 2'd2;
   localparam logic [1:0] EMERG_HIGH  = 2'd3;

   localparam logic [7:0]  COOLER_FLOOR = 8'd1;
   localparam logic [7:0]  COOLER_CEIL  = 8'd194;
   localparam logic [10:0] CPU_FILTER_RESET = 11'd250;

   typedef struct packed {
      logic [9:0]  battery_baseline;
      logic [7:0]  dead_zone;
      logic [7:0]  big_step_zone;
      logic [3:0]  cooldown_ticks;
      logic [10:0] cpu_level1_threshold;
      logic [10:0] cpu_level2_threshold;
      logic [10:0] cpu_level3_threshold;
      logic [10:0] cpu_clear_threshold;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  battery_temp;
      logic        battery_valid;
      logic [10:0] cpu_temp;
      logic        cpu_valid;
   } item_type;

   typedef struct packed {
      logic [3:0]  base_level;
      logic [1:0]  emerg_level;
      logic [10:0] cpu_filtered;
      logic        filter_primed;
      logic [3:0]  cooldown_left;
      logic [9:0]  last_battery_temp;
      logic        last_battery_known;
      logic [3:0]  last_sent_level;
      logic        last_sent_known;
   } state_type;

   typedef struct packed {
      logic        changed;
      logic [3:0]  applied_level;
      logic        run_mode;
      logic [5:0]  target_temp;
      logic [12:0] fixed_fan_rpm;
      logic [7:0]  cooler_intensity;
      logic [12:0] fan_rpm_limit;
      logic [1:0]  emergency_now;
      logic [3:0]  base_level_now;
   } result_type;

   localparam state_type STATE_RESET = '{
      base_level:         4'd0,
      emerg_level:        EMERG_NONE,
      cpu_filtered:       CPU_FILTER_RESET,
      filter_primed:      1'b0,
      cooldown_left:      4'd0,
      last_battery_temp:  10'd0,
      last_battery_known: 1'b0,
      last_sent_level:    4'd0,
      last_sent_known:    1'b0
   };

   // Minimum level forced by each emergency level
   function automatic logic [3:0] forced_level(input logic [1:0] emerg);
      logic [3:0] lvl;
      unique case (emerg)
         EMERG_NONE: lvl = 4'd0;
         EMERG_LOW:  lvl = 4'd5;
         EMERG_MID:  lvl = 4'd7;
         EMERG_HIGH: lvl = 4'd9;
      endcase
      return lvl;
   endfunction

   function automatic logic [12:0] fan_rpm(input logic [3:0] lvl);
      logic [12:0] rpm;
      unique case (lvl)
         4'd0:    rpm = 13'd2000;
         4'd1:    rpm = 13'd2200;
         4'd2:    rpm = 13'd2500;
         4'd3:    rpm = 13'd2900;
         4'd4:    rpm = 13'd3400;
         4'd5:    rpm = 13'd4000;
         4'd6:    rpm = 13'd4600;
         4'd7:    rpm = 13'd5100;
         4'd8:    rpm = 13'd5500;
         4'd9:    rpm = 13'd5800;
         4'd10:   rpm = 13'd6000;
         default: rpm = 13'd0;
      endcase
      return rpm;
   endfunction

   // 1 = fixed power mode, 0 = smart target mode
   function automatic logic run_mode(input logic [3:0] lvl);
      logic mode;
      unique case (lvl)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd10: mode = 1'b1;
         default:                       mode = 1'b0;
      endcase
      return mode;
   endfunction

   function automatic logic [5:0] target_temp(input logic [3:0] lvl);
      logic [5:0] tgt;
      unique case (lvl)
         4'd4:    tgt = 6'd18;
         4'd5:    tgt = 6'd16;
         4'd6:    tgt = 6'd15;
         4'd7:    tgt = 6'd14;
         4'd8:    tgt = 6'd13;
         4'd9:    tgt = 6'd12;
         default: tgt = 6'd20;
      endcase
      return tgt;
   endfunction

   // Cooler strength, already clamped to the floor and ceiling
   function automatic logic [7:0] cooler_level(input logic [3:0] lvl);
      logic [7:0] raw;
      logic [7:0] clamped;
      unique case (lvl)
         4'd0:    raw = 8'd20;
         4'd1:    raw = 8'd40;
         4'd2:    raw = 8'd60;
         4'd3:    raw = 8'd80;
         4'd10:   raw = 8'd190;
         default: raw = 8'd0;
      endcase
      if (raw < COOLER_FLOOR) begin
         clamped = COOLER_FLOOR;
      end else if (raw > COOLER_CEIL) begin
         clamped = COOLER_CEIL;
      end else begin
         clamped = raw;
      end
      return clamped;
   endfunction

endpackage

@@ design/tflc_csr.sv @@
`timescale 1ns / 1ps

module tflc_csr import tflc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg_o
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg_o     = cfg_ff;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BATTERY_BASELINE: cfg_in.battery_baseline     = csr_data[9:0];
            CSR_DEAD_ZONE:        cfg_in.dead_zone            = csr_data[7:0];
            CSR_BIG_STEP_ZONE:    cfg_in.big_step_zone        = csr_data[7:0];
            CSR_COOLDOWN_TICKS:   cfg_in.cooldown_ticks       = csr_data[3:0];
            CSR_CPU_LEVEL1:       cfg_in.cpu_level1_threshold = csr_data;
            CSR_CPU_LEVEL2:       cfg_in.cpu_level2_threshold = csr_data;
            CSR_CPU_LEVEL3:       cfg_in.cpu_level3_threshold = csr_data;
            CSR_CPU_CLEAR:        cfg_in.cpu_clear_threshold  = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.battery_baseline     <= 10'd350;
         cfg_ff.dead_zone            <= 8'd7;
         cfg_ff.big_step_zone        <= 8'd20;
         cfg_ff.cooldown_ticks       <= 4'd4;
         cfg_ff.cpu_level1_threshold <= 11'd650;
         cfg_ff.cpu_level2_threshold <= 11'd750;
         cfg_ff.cpu_level3_threshold <= 11'd850;
         cfg_ff.cpu_clear_threshold  <= 11'd550;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/tflc_step.sv @@
`timescale 1ns / 1ps

module tflc_step import tflc_pkg::*; (
   input  item_type   item_i,
   input  cfg_type    cfg_i,
   input  state_type  state_i,
   output state_type  state_o,
   output result_type result_o
);

   state_type   nxt;
   logic [12:0] blend;
   logic [10:0] filt;
   logic [1:0]  emerg;
   logic [9:0]  init_diff;
   logic [17:0] init_prod;
   logic [6:0]  init_quot;
   logic [3:0]  init_level;
   logic        batt_low;
   logic [9:0]  mag;
   logic [1:0]  step;
   logic        take_batt;
   logic [4:0]  sum;
   logic [3:0]  forced;
   logic [3:0]  lvl;

   always_comb begin
      nxt       = state_i;
      emerg     = state_i.emerg_level;
      take_batt = 1'b0;
      sum       = 5'd0;

      // Filter: (new*25 + old*75)/100 equals (new + 3*old)/4
      blend = {2'b00, item_i.cpu_temp} + {1'b0, state_i.cpu_filtered, 1'b0}
            + {2'b00, state_i.cpu_filtered};
      filt  = state_i.filter_primed ? blend[12:2] : item_i.cpu_temp;

      // Restart level: (batt - baseline)/10 by reciprocal, exact below 1024
      init_diff  = item_i.battery_temp - cfg_i.battery_baseline;
      init_prod  = {8'd0, init_diff} * 18'd205;
      init_quot  = init_prod[17:11];
      if (!item_i.battery_valid || item_i.battery_temp <= cfg_i.battery_baseline) begin
         init_level = 4'd0;
      end else if (init_quot > {3'd0, LEVEL_TOP}) begin
         init_level = LEVEL_TOP;
      end else begin
         init_level = init_quot[3:0];
      end

      // Battery deviation from the baseline
      batt_low = item_i.battery_temp < cfg_i.battery_baseline;
      mag      = batt_low ? (cfg_i.battery_baseline - item_i.battery_temp)
                          : (item_i.battery_temp - cfg_i.battery_baseline);
      if (mag > {2'b00, cfg_i.big_step_zone}) begin
         step = 2'd2;
      end else if (mag > {2'b00, cfg_i.dead_zone}) begin
         step = 2'd1;
      end else begin
         step = 2'd0;
      end

      if (item_i.opcode == OP_RESTART) begin
         nxt            = STATE_RESET;
         nxt.base_level = init_level;
      end else begin
         // Move the emergency level with hysteresis
         if (item_i.cpu_valid) begin
            nxt.cpu_filtered  = filt;
            nxt.filter_primed = 1'b1;
            priority if (filt > cfg_i.cpu_level3_threshold) begin
               emerg = EMERG_HIGH;
            end else if (filt > cfg_i.cpu_level2_threshold) begin
               emerg = EMERG_MID;
            end else if (filt > cfg_i.cpu_level1_threshold) begin
               emerg = EMERG_LOW;
            end else if (filt < cfg_i.cpu_clear_threshold) begin
               emerg = EMERG_NONE;
            end else if (filt < cfg_i.cpu_level1_threshold
                         && state_i.emerg_level >= EMERG_MID) begin
               emerg = EMERG_LOW;
            end else if (filt < cfg_i.cpu_level2_threshold
                         && state_i.emerg_level == EMERG_HIGH) begin
               emerg = EMERG_MID;
            end else begin
               emerg = state_i.emerg_level;
            end
            // Cap the base level when leaving an emergency level
            if (emerg != state_i.emerg_level) begin
               if (state_i.emerg_level == EMERG_HIGH && state_i.base_level > 4'd9) begin
                  nxt.base_level = 4'd9;
               end
               if (state_i.emerg_level == EMERG_MID && emerg < EMERG_MID
                   && state_i.base_level > 4'd7) begin
                  nxt.base_level = 4'd7;
               end
               if (state_i.emerg_level == EMERG_LOW && emerg == EMERG_NONE
                   && state_i.base_level > 4'd5) begin
                  nxt.base_level = 4'd5;
               end
               nxt.cooldown_left = cfg_i.cooldown_ticks;
               nxt.emerg_level   = emerg;
            end
         end

         // Count down the cooldown, then step the base level
         if (nxt.cooldown_left != 4'd0) begin
            nxt.cooldown_left = nxt.cooldown_left - 4'd1;
         end
         take_batt = item_i.battery_valid
                   && !(state_i.last_battery_known
                        && item_i.battery_temp == state_i.last_battery_temp)
                   && nxt.cooldown_left == 4'd0;
         if (take_batt) begin
            nxt.last_battery_temp  = item_i.battery_temp;
            nxt.last_battery_known = 1'b1;
            if (step != 2'd0) begin
               if (batt_low) begin
                  nxt.base_level = (nxt.base_level < {2'b00, step}) ? 4'd0
                                 : nxt.base_level - {2'b00, step};
               end else begin
                  sum = {1'b0, nxt.base_level} + {3'b000, step};
                  nxt.base_level = (sum > {1'b0, LEVEL_TOP}) ? LEVEL_TOP : sum[3:0];
               end
               nxt.cooldown_left = cfg_i.cooldown_ticks;
            end
         end
      end

      // Apply the forced minimum and report a change of level
      forced = forced_level(nxt.emerg_level);
      lvl    = (nxt.base_level > forced) ? nxt.base_level : forced;
      if (lvl > LEVEL_TOP) begin
         lvl = LEVEL_TOP;
      end
      result_o.changed = !nxt.last_sent_known || nxt.last_sent_level != lvl;
      nxt.last_sent_known = 1'b1;
      nxt.last_sent_level = lvl;

      result_o.applied_level    = lvl;
      result_o.run_mode         = run_mode(lvl);
      result_o.target_temp      = target_temp(lvl);
      result_o.fixed_fan_rpm    = run_mode(lvl) ? fan_rpm(lvl) : 13'd0;
      result_o.cooler_intensity = run_mode(lvl) ? cooler_level(lvl) : 8'd0;
      result_o.fan_rpm_limit    = run_mode(lvl) ? 13'd0 : fan_rpm(lvl);
      result_o.emergency_now    = nxt.emerg_level;
      result_o.base_level_now   = nxt.base_level;

      state_o = nxt;
   end

endmodule

@@ design/thermal_fan_level_controller_core.sv @@
`timescale 1ns / 1ps
// Thermal fan level controller.
// The req_ channel carries one tick or restart item: opcode, battery_temp,
// battery_valid, cpu_temp and cpu_valid. For every item the rsp_ channel
// returns exactly one result with the applied level, the fan and cooler
// settings, the emergency level and the base level, in order.
// An accepted item lands in an input register; once the result register is
// free, the whole update runs in one pass of logic into the result register
// and the controller state. One item per cycle is sustained while the
// receiver holds rsp_ready high: the input register and the result register
// each hold one item, so a new item is taken while a finished result still
// waits.
// When the receiver holds rsp_ready low, the result stays in place; the
// input register still takes one more item, and req_ready drops only when
// both registers are full.
// The csr_ channel writes the eight configuration registers by index and
// is always ready; write it only while no item is in flight.
// Synchronous reset loads the default configuration, clears the state
// (filter value 250, not primed) and empties both registers.

module thermal_fan_level_controller_core import tflc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic [9:0]             req_battery_temp,
   input  logic                   req_battery_valid,
   input  logic [10:0]            req_cpu_temp,
   input  logic                   req_cpu_valid,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_changed,
   output logic [3:0]             rsp_applied_level,
   output logic                   rsp_run_mode,
   output logic [5:0]             rsp_target_temp,
   output logic [12:0]            rsp_fixed_fan_rpm,
   output logic [7:0]             rsp_cooler_intensity,
   output logic [12:0]            rsp_fan_rpm_limit,
   output logic [1:0]             rsp_emergency_now,
   output logic [3:0]             rsp_base_level_now,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg;
   item_type   in_item_ff;
   logic       in_valid_ff;
   logic       in_valid_in;
   state_type  state_ff;
   state_type  state_next;
   result_type step_result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       advance;
   logic       req_accept;

   tflc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_o     (cfg)
   );

   tflc_step u_step (
      .item_i   (in_item_ff),
      .cfg_i    (cfg),
      .state_i  (state_ff),
      .state_o  (state_next),
      .result_o (step_result)
   );

   // Move an item to the result register when that register is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.opcode        <= req_opcode;
         in_item_ff.battery_temp  <= req_battery_temp;
         in_item_ff.battery_valid <= req_battery_valid;
         in_item_ff.cpu_temp      <= req_cpu_temp;
         in_item_ff.cpu_valid     <= req_cpu_valid;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_changed          = result_ff.changed;
   assign rsp_applied_level    = result_ff.applied_level;
   assign rsp_run_mode         = result_ff.run_mode;
   assign rsp_target_temp      = result_ff.target_temp;
   assign rsp_fixed_fan_rpm    = result_ff.fixed_fan_rpm;
   assign rsp_cooler_intensity = result_ff.cooler_intensity;
   assign rsp_fan_rpm_limit    = result_ff.fan_rpm_limit;
   assign rsp_emergency_now    = result_ff.emergency_now;
   assign rsp_base_level_now   = result_ff.base_level_now;

   // Base level never leaves 0..10
   a_base_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.base_level <= LEVEL_TOP)
      else $error("base level out of range");

   // Applied level covers both the base level and the forced minimum
   a_level_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_applied_level >= rsp_base_level_now
                     && rsp_applied_level >= forced_level(rsp_emergency_now)))
      else $error("applied level below base or forced minimum");

   // A restart reports a change and clears the emergency level
   a_restart_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.opcode == OP_RESTART)
      |=> (rsp_valid && rsp_changed && rsp_emergency_now == EMERG_NONE))
      else $error("restart result wrong");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import tflc_pkg::*;

   // Clock, reset and block ports
   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_opcode;
   logic [9:0]             req_battery_temp;
   logic                   req_battery_valid;
   logic [10:0]            req_cpu_temp;
   logic                   req_cpu_valid;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_changed;
   logic [3:0]             rsp_applied_level;
   logic                   rsp_run_mode;
   logic [5:0]             rsp_target_temp;
   logic [12:0]            rsp_fixed_fan_rpm;
   logic [7:0]             rsp_cooler_intensity;
   logic [12:0]            rsp_fan_rpm_limit;
   logic [1:0]             rsp_emergency_now;
   logic [3:0]             rsp_base_level_now;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // Level to fan and cooler settings
   logic [12:0] rpm_for_level [0:10] =
      '{13'd2000, 13'd2200, 13'd2500, 13'd2900, 13'd3400, 13'd4000,
        13'd4600, 13'd5100, 13'd5500, 13'd5800, 13'd6000};
   logic        fixed_mode_for_level [0:10] =
      '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
   logic [5:0]  target_for_level [0:10] =
      '{6'd20, 6'd20, 6'd20, 6'd20, 6'd18, 6'd16, 6'd15, 6'd14, 6'd13, 6'd12, 6'd20};
   logic [7:0]  cooler_for_level [0:10] =
      '{8'd20, 8'd40, 8'd60, 8'd80, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd190};
   logic [3:0]  floor_for_emerg [0:3] = '{4'd0, 4'd5, 4'd7, 4'd9};

   // Predictor copy of the controller
   cfg_type    regs;
   state_type  ctl;
   result_type pending_fan_results [$];

   typedef struct {
      item_type   stim;
      bit         typed;
      logic       changed;
      logic [3:0] level;
      logic [1:0] emerg;
      logic [3:0] base;
   } directed_row_type;

   directed_row_type directed_rows [$];

   bit sender_quiet;
   bit receiver_quiet;
   bit hold_results;
   int batt_walk;
   int cpu_walk;
   int mismatches;
   int items_sent;
   int restarts_sent;
   int results_checked;
   int settings_applied;

   thermal_fan_level_controller_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_battery_temp     (req_battery_temp),
      .req_battery_valid    (req_battery_valid),
      .req_cpu_temp         (req_cpu_temp),
      .req_cpu_valid        (req_cpu_valid),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_changed          (rsp_changed),
      .rsp_applied_level    (rsp_applied_level),
      .rsp_run_mode         (rsp_run_mode),
      .rsp_target_temp      (rsp_target_temp),
      .rsp_fixed_fan_rpm    (rsp_fixed_fan_rpm),
      .rsp_cooler_intensity (rsp_cooler_intensity),
      .rsp_fan_rpm_limit    (rsp_fan_rpm_limit),
      .rsp_emergency_now    (rsp_emergency_now),
      .rsp_base_level_now   (rsp_base_level_now),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Advance the controller copy by one item and return its fan settings
   function automatic result_type next_fan_result(input item_type it);
      result_type  r;
      logic [1:0]  prev_emerg;
      logic [1:0]  new_emerg;
      logic [10:0] t;
      logic [3:0]  lvl;
      logic [7:0]  cooler;
      int          start_lvl;
      int          diff;
      int          mag;
      int          delta;
      int          lv;
      if (it.opcode == OP_RESTART) begin
         start_lvl = 0;
         if (it.battery_valid && it.battery_temp > regs.battery_baseline) begin
            start_lvl = (int'(it.battery_temp) - int'(regs.battery_baseline)) / 10;
            if (start_lvl > int'(LEVEL_TOP)) start_lvl = int'(LEVEL_TOP);
         end
         ctl = STATE_RESET;
         ctl.base_level = 4'(start_lvl);
      end else begin
         // Filter the cpu reading and move the emergency level
         if (it.cpu_valid) begin
            if (!ctl.filter_primed) begin
               ctl.cpu_filtered = it.cpu_temp;
               ctl.filter_primed = 1'b1;
            end else begin
               ctl.cpu_filtered = 11'((int'(it.cpu_temp) * 25 +
                                      int'(ctl.cpu_filtered) * 75) / 100);
            end
            t = ctl.cpu_filtered;
            prev_emerg = ctl.emerg_level;
            new_emerg = prev_emerg;
            if (t > regs.cpu_level3_threshold) new_emerg = EMERG_HIGH;
            else if (t > regs.cpu_level2_threshold) new_emerg = EMERG_MID;
            else if (t > regs.cpu_level1_threshold) new_emerg = EMERG_LOW;
            else if (t < regs.cpu_clear_threshold) new_emerg = EMERG_NONE;
            else if (t < regs.cpu_level1_threshold && prev_emerg >= EMERG_MID)
               new_emerg = EMERG_LOW;
            else if (t < regs.cpu_level2_threshold && prev_emerg == EMERG_HIGH)
               new_emerg = EMERG_MID;
            if (new_emerg != prev_emerg) begin
               if (prev_emerg == EMERG_HIGH && ctl.base_level > 4'd9) ctl.base_level = 4'd9;
               if (prev_emerg == EMERG_MID && new_emerg < EMERG_MID && ctl.base_level > 4'd7)
                  ctl.base_level = 4'd7;
               if (prev_emerg == EMERG_LOW && new_emerg == EMERG_NONE &&
                   ctl.base_level > 4'd5)
                  ctl.base_level = 4'd5;
               ctl.cooldown_left = regs.cooldown_ticks;
               ctl.emerg_level = new_emerg;
            end
         end
         // Step the base level from the battery reading
         if (ctl.cooldown_left != 4'd0) ctl.cooldown_left = ctl.cooldown_left - 4'd1;
         if (it.battery_valid &&
             !(ctl.last_battery_known && it.battery_temp == ctl.last_battery_temp) &&
             ctl.cooldown_left == 4'd0) begin
            diff = int'(it.battery_temp) - int'(regs.battery_baseline);
            mag = (diff < 0) ? -diff : diff;
            delta = 0;
            if (mag > int'(regs.big_step_zone)) delta = 2;
            else if (mag > int'(regs.dead_zone)) delta = 1;
            if (diff < 0) delta = -delta;
            ctl.last_battery_temp = it.battery_temp;
            ctl.last_battery_known = 1'b1;
            if (delta != 0) begin
               lv = int'(ctl.base_level) + delta;
               if (lv < 0) lv = 0;
               if (lv > int'(LEVEL_TOP)) lv = int'(LEVEL_TOP);
               ctl.base_level = 4'(lv);
               ctl.cooldown_left = regs.cooldown_ticks;
            end
         end
      end

      // Apply the forced minimum and look up the settings
      lvl = ctl.base_level;
      if (floor_for_emerg[ctl.emerg_level] > lvl) lvl = floor_for_emerg[ctl.emerg_level];
      if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
      r.changed = !ctl.last_sent_known || ctl.last_sent_level != lvl;
      ctl.last_sent_known = 1'b1;
      ctl.last_sent_level = lvl;
      cooler = cooler_for_level[lvl];
      if (cooler < COOLER_FLOOR) cooler = COOLER_FLOOR;
      if (cooler > COOLER_CEIL) cooler = COOLER_CEIL;
      r.applied_level    = lvl;
      r.run_mode         = fixed_mode_for_level[lvl];
      r.target_temp      = target_for_level[lvl];
      r.fixed_fan_rpm    = r.run_mode ? rpm_for_level[lvl] : 13'd0;
      r.cooler_intensity = r.run_mode ? cooler : 8'd0;
      r.fan_rpm_limit    = r.run_mode ? 13'd0 : rpm_for_level[lvl];
      r.emergency_now    = ctl.emerg_level;
      r.base_level_now   = ctl.base_level;
      return r;
   endfunction

   function automatic int draw_wait(input bit quiet);
      if (quiet) return 0;
      if ($urandom_range(0, 2) == 0) return 0;
      return int'($urandom_range(0, 17));
   endfunction

   // Mostly readings near the baseline and a cpu trace that wanders across thresholds
   function automatic item_type draw_item();
      item_type it;
      int       b;
      int       roll;
      roll = int'($urandom_range(0, 99));
      it.opcode = (roll < 8) ? OP_RESTART : OP_TICK;
      roll = int'($urandom_range(0, 99));
      if (roll < 25) b = batt_walk;
      else if (roll < 40) b = int'($urandom_range(0, 1023));
      else b = int'(regs.battery_baseline) + int'($urandom_range(0, 120)) - 50;
      if (b < 0) b = 0;
      if (b > 1023) b = 1023;
      batt_walk = b;
      it.battery_temp = 10'(b);
      it.battery_valid = ($urandom_range(0, 9) != 0);
      roll = int'($urandom_range(0, 99));
      if (roll < 8) cpu_walk = int'($urandom_range(0, 2047));
      else if (roll < 16) cpu_walk = int'($urandom_range(0, 1500));
      else cpu_walk = cpu_walk + int'($urandom_range(0, 300)) - 150;
      if (cpu_walk < 0) cpu_walk = 0;
      if (cpu_walk > 2047) cpu_walk = 2047;
      it.cpu_temp = 11'(cpu_walk);
      it.cpu_valid = ($urandom_range(0, 6) != 0);
      return it;
   endfunction

   task automatic add_row(input logic op, input int batt, input logic bvalid,
                          input int cpu, input logic cvalid, input bit typed,
                          input logic chg, input int lvl, input logic [1:0] emerg,
                          input int base);
      directed_row_type row;
      row.stim.opcode        = op;
      row.stim.battery_temp  = 10'(batt);
      row.stim.battery_valid = bvalid;
      row.stim.cpu_temp      = 11'(cpu);
      row.stim.cpu_valid     = cvalid;
      row.typed   = typed;
      row.changed = chg;
      row.level   = 4'(lvl);
      row.emerg   = emerg;
      row.base    = 4'(base);
      directed_rows.push_back(row);
   endtask

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input item_type it, input result_type want);
      int gap;
      gap = draw_wait(sender_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode        = it.opcode;
      req_battery_temp  = it.battery_temp;
      req_battery_valid = it.battery_valid;
      req_cpu_temp      = it.cpu_temp;
      req_cpu_valid     = it.cpu_valid;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_fan_results.push_back(want);
      items_sent++;
      if (it.opcode == OP_RESTART) restarts_sent++;
   endtask

   task automatic random_items(input int count);
      item_type   it;
      result_type want;
      for (int k = 0; k < count; k++) begin
         it = draw_item();
         want = next_fan_result(it);
         send_item(it, want);
      end
   endtask

   // Drop valid and wait until every result has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_fan_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index = idx;
      csr_data  = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BATTERY_BASELINE: regs.battery_baseline     = data[9:0];
         CSR_DEAD_ZONE:        regs.dead_zone            = data[7:0];
         CSR_BIG_STEP_ZONE:    regs.big_step_zone        = data[7:0];
         CSR_COOLDOWN_TICKS:   regs.cooldown_ticks       = data[3:0];
         CSR_CPU_LEVEL1:       regs.cpu_level1_threshold = data;
         CSR_CPU_LEVEL2:       regs.cpu_level2_threshold = data;
         CSR_CPU_LEVEL3:       regs.cpu_level3_threshold = data;
         CSR_CPU_CLEAR:        regs.cpu_clear_threshold  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Reprogram every register once the block has gone idle
   task automatic apply_settings(input int base, input int dz, input int bz, input int cd,
                                 input int l1, input int l2, input int l3, input int clr);
      drain_results();
      repeat (4) @(negedge clock);
      write_reg(CSR_BATTERY_BASELINE, 11'(base));
      write_reg(CSR_DEAD_ZONE,        11'(dz));
      write_reg(CSR_BIG_STEP_ZONE,    11'(bz));
      write_reg(CSR_COOLDOWN_TICKS,   11'(cd));
      write_reg(CSR_CPU_LEVEL1,       11'(l1));
      write_reg(CSR_CPU_LEVEL2,       11'(l2));
      write_reg(CSR_CPU_LEVEL3,       11'(l3));
      write_reg(CSR_CPU_CLEAR,        11'(clr));
      batt_walk = base;
      settings_applied++;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Result side: random stalls, one long hold on request, check in order
   initial begin
      int         stall;
      result_type want;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait(receiver_quiet);
         if (hold_results) begin
            stall = 90;
            hold_results = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_fan_results.size() == 0) begin
            $error("result arrived with no item outstanding");
            mismatches++;
         end else begin
            want = pending_fan_results.pop_front();
            check_field("changed",          want.changed,          rsp_changed);
            check_field("applied_level",    want.applied_level,    rsp_applied_level);
            check_field("run_mode",         want.run_mode,         rsp_run_mode);
            check_field("target_temp",      want.target_temp,      rsp_target_temp);
            check_field("fixed_fan_rpm",    want.fixed_fan_rpm,    rsp_fixed_fan_rpm);
            check_field("cooler_intensity", want.cooler_intensity, rsp_cooler_intensity);
            check_field("fan_rpm_limit",    want.fan_rpm_limit,    rsp_fan_rpm_limit);
            check_field("emergency_now",    want.emergency_now,    rsp_emergency_now);
            check_field("base_level_now",   want.base_level_now,   rsp_base_level_now);
            results_checked++;
         end
         @(negedge clock);
      end
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus
   initial begin
      result_type want;
      int         l1;
      int         l2;
      int         l3;
      int         clr;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_TICK;
      req_battery_temp  = '0;
      req_battery_valid = 1'b0;
      req_cpu_temp      = '0;
      req_cpu_valid     = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_BATTERY_BASELINE;
      csr_data          = '0;
      sender_quiet      = 1'b0;
      receiver_quiet    = 1'b0;
      hold_results      = 1'b0;
      mismatches        = 0;
      items_sent        = 0;
      restarts_sent     = 0;
      results_checked   = 0;
      settings_applied  = 0;
      cpu_walk          = 600;
      batt_walk         = 350;
      regs = '{battery_baseline: 10'd350, dead_zone: 8'd7, big_step_zone: 8'd20,
               cooldown_ticks: 4'd4, cpu_level1_threshold: 11'd650,
               cpu_level2_threshold: 11'd750, cpu_level3_threshold: 11'd850,
               cpu_clear_threshold: 11'd550};
      ctl = STATE_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items on the reset settings; typed rows hold the obvious answers
      //       op           batt  bv    cpu  cv   typed chg  lvl emerg       base
      add_row(OP_TICK,       0,   1'b0,    0, 1'b0, 1, 1'b1,  0, EMERG_NONE,  0);
      add_row(OP_TICK,       0,   1'b0,    0, 1'b0, 1, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,     380,   1'b1,    0, 1'b0, 1, 1'b1,  2, EMERG_NONE,  2);
      add_row(OP_TICK,     380,   1'b1,    0, 1'b0, 1, 1'b0,  2, EMERG_NONE,  2);
      add_row(OP_TICK,       0,   1'b0,  900, 1'b1, 1, 1'b1,  9, EMERG_HIGH,  2);
      add_row(OP_TICK,       0,   1'b0,    0, 1'b1, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,       0,   1'b0,    0, 1'b1, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,    1023,   1'b1, 2047, 1'b1, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,       0,   1'b1,    0, 1'b0, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_RESTART, 1023,   1'b1,    0, 1'b0, 1, 1'b1, 10, EMERG_NONE, 10);
      add_row(OP_RESTART,  355,   1'b1,    0, 1'b0, 1, 1'b1,  0, EMERG_NONE,  0);
      add_row(OP_RESTART,  500,   1'b0, 1500, 1'b1, 1, 1'b1,  0, EMERG_NONE,  0);
      add_row(OP_RESTART,  450,   1'b1, 1500, 1'b1, 1, 1'b1, 10, EMERG_NONE, 10);
      add_row(OP_TICK,       0,   1'b0, 1500, 1'b1, 1, 1'b0, 10, EMERG_HIGH, 10);
      // Cool down through every emergency level, capping the base level each time
      add_row(OP_TICK,       0,   1'b0,    0, 1'b1, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,       0,   1'b0,    0, 1'b1, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,       0,   1'b0,    0, 1'b1, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,       0,   1'b0,    0, 1'b1, 0, 1'b0,  0, EMERG_NONE,  0);
      // Battery readings held off by the cooldown, then one inside the deadband and one up by one
      add_row(OP_TICK,     300,   1'b1,    0, 1'b0, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,     301,   1'b1,    0, 1'b0, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,     345,   1'b1,    0, 1'b0, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,     360,   1'b1,    0, 1'b0, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_RESTART,  350,   1'b1,    0, 1'b0, 1, 1'b1,  0, EMERG_NONE,  0);
      // Filter lands exactly on the level 1 threshold from level 3: drop to level 2
      add_row(OP_TICK,     357,   1'b1,  860, 1'b1, 0, 1'b0,  0, EMERG_NONE,  0);
      add_row(OP_TICK,     358,   1'b1,   20, 1'b1, 0, 1'b0,  0, EMERG_NONE,  0);

      foreach (directed_rows[i]) begin
         want = next_fan_result(directed_rows[i].stim);
         if (directed_rows[i].typed) begin
            want.changed        = directed_rows[i].changed;
            want.applied_level  = directed_rows[i].level;
            want.emergency_now  = directed_rows[i].emerg;
            want.base_level_now = directed_rows[i].base;
         end
         send_item(directed_rows[i].stim, want);
      end

      // Everything at its lowest
      apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
      random_items(100);

      // Zones and cooldown at their highest, cpu thresholds at 1500, with no idling on either side
      sender_quiet = 1'b1;
      receiver_quiet = 1'b1;
      apply_settings(1023, 255, 255, 15, 1500, 1500, 1500, 1500);
      random_items(100);
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;

      // Reset values again; hold results off while items keep coming, then pause
      apply_settings(350, 7, 20, 4, 650, 750, 850, 550);
      random_items(60);
      hold_results = 1'b1;
      sender_quiet = 1'b1;
      random_items(30);
      sender_quiet = 1'b0;
      random_items(30);
      drain_results();
      random_items(60);

      // Random thresholds in any order
      apply_settings(int'($urandom_range(0, 1023)), int'($urandom_range(0, 255)),
                     int'($urandom_range(0, 255)), int'($urandom_range(0, 15)),
                     int'($urandom_range(0, 1500)), int'($urandom_range(0, 1500)),
                     int'($urandom_range(0, 1500)), int'($urandom_range(0, 1500)));
      random_items(110);

      // Tight ordered thresholds and short cooldowns keep the levels moving
      for (int p = 0; p < 2; p++) begin
         l1  = int'($urandom_range(400, 900));
         clr = l1 - int'($urandom_range(0, 80));
         l2  = l1 + int'($urandom_range(0, 60));
         l3  = l2 + int'($urandom_range(0, 60));
         apply_settings(int'($urandom_range(250, 600)), int'($urandom_range(0, 10)),
                        int'($urandom_range(10, 30)), int'($urandom_range(0, 3)),
                        l1, l2, l3, clr);
         random_items(110);
      end

      drain_results();
      repeat (24) @(negedge clock);
      $display("Covered %0d items (%0d restarts) under %0d register settings plus reset values;",
               items_sent, restarts_sent, settings_applied);
      $display("checked %0d results field by field, %0d mismatches.",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
